FILE: src/bounded_sorted_timestamp_index_core_defines.svh
`ifndef BOUNDED_SORTED_TIMESTAMP_INDEX_CORE_DEFINES_SVH
`define BOUNDED_SORTED_TIMESTAMP_INDEX_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BSTI_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define BSTI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/bsti_pkg.sv
package bsti_pkg;

	localparam int STAMP_W = 40;
	localparam int CFG_W = 9;
	localparam int STATUS_W = 3;
	localparam int IN_DATA_W = 3 * STAMP_W;
	localparam int OUT_USER_W = STATUS_W + 1;
	localparam int GRP_W = 16;

	localparam int DEF_TABLE_DEPTH = 256;
	localparam int DEF_MAX_BURST = 64;

	localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 9'd240;

	localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] STS_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] STS_EVICTED = 3'd2;
	localparam logic [STATUS_W-1:0] STS_ENTRY = 3'd3;
	localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd4;

	typedef struct packed {
		logic cmp_en;
		logic ins_en;
		logic evict;
		logic rd_load;
		logic rd_shift;
	} chain_ctrl_t;

	typedef struct packed {
		logic valid;
		logic lt;
		logic le_s;
		logic le_b;
		logic in_range;
		logic rd_tag;
		logic rd_last;
	} cell_flags_t;

	typedef struct packed {
		logic dup;
		logic kill;
		logic le_s0;
		logic le_b0;
		logic rd_tag0;
		logic rd_last0;
	} chain_stat_t;

endpackage

FILE: src/bsti_cell.sv
module bsti_cell #(
	parameter int IDX = 0,
	parameter int CNT_W = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bsti_pkg::chain_ctrl_t         ctrl,
	input  logic [CNT_W-1:0]              count,
	input  logic [bsti_pkg::STAMP_W-1:0]  op_a,
	input  logic [bsti_pkg::STAMP_W-1:0]  op_b,
	input  logic                          prev_lt,
	input  logic [bsti_pkg::STAMP_W-1:0]  prev_stamp,
	input  bsti_pkg::cell_flags_t         next_flags,
	input  logic [bsti_pkg::STAMP_W-1:0]  next_stamp,
	input  logic [bsti_pkg::STAMP_W-1:0]  next_rd_stamp,
	output bsti_pkg::cell_flags_t         flags,
	output logic [bsti_pkg::STAMP_W-1:0]  stamp,
	output logic [bsti_pkg::STAMP_W-1:0]  rd_stamp,
	output logic                          eq,
	output logic                          kill
);
	import bsti_pkg::*;

	logic [STAMP_W-1:0] stamp_q;
	logic [STAMP_W-1:0] rd_stamp_q;
	logic lt_q;
	logic eq_q;
	logic le_b_q;
	logic rd_tag_q;
	logic rd_last_q;
	logic valid;
	logic le_s;
	logic in_range;
	logic s_mark;
	logic e_mark;
	logic tag_load;
	logic last_load;

	assign valid = count > CNT_W'(IDX);
	assign le_s = lt_q | eq_q;
	assign in_range = le_b_q & ~next_flags.le_s;
	assign s_mark = le_s & ~next_flags.le_s;
	assign e_mark = le_b_q & ~next_flags.le_b;
	assign tag_load = in_range | s_mark | e_mark;
	assign last_load = (in_range & ~next_flags.in_range) | (s_mark & ~le_b_q);

	assign flags.valid = valid;
	assign flags.lt = lt_q;
	assign flags.le_s = le_s;
	assign flags.le_b = le_b_q;
	assign flags.in_range = in_range;
	assign flags.rd_tag = rd_tag_q;
	assign flags.rd_last = rd_last_q;
	assign stamp = stamp_q;
	assign rd_stamp = rd_stamp_q;
	assign eq = eq_q;
	assign kill = valid & ~next_flags.valid & lt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
			le_b_q <= 1'b0;
			rd_tag_q <= 1'b0;
			rd_last_q <= 1'b0;
		end else begin
			if (ctrl.cmp_en) begin
				lt_q <= valid & (stamp_q < op_a);
				eq_q <= valid & (stamp_q == op_a);
				le_b_q <= valid & (stamp_q <= op_b);
			end
			if (ctrl.rd_load) begin
				rd_tag_q <= tag_load;
				rd_last_q <= last_load;
			end else if (ctrl.rd_shift) begin
				rd_tag_q <= next_flags.rd_tag;
				rd_last_q <= next_flags.rd_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (ctrl.evict) begin
				// shift smaller entries down, drop the smallest
				if (lt_q) begin
					stamp_q <= next_flags.lt ? next_stamp : op_a;
				end
			end else if (!lt_q) begin
				stamp_q <= prev_lt ? op_a : prev_stamp;
			end
		end
		if (ctrl.rd_load) begin
			rd_stamp_q <= stamp_q;
		end else if (ctrl.rd_shift) begin
			rd_stamp_q <= next_rd_stamp;
		end
	end

endmodule

FILE: src/bsti_chain.sv
module bsti_chain #(
	parameter int TABLE_DEPTH = bsti_pkg::DEF_TABLE_DEPTH,
	parameter int CNT_W = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bsti_pkg::chain_ctrl_t         ctrl,
	input  logic [CNT_W-1:0]              count,
	input  logic [bsti_pkg::STAMP_W-1:0]  op_a,
	input  logic [bsti_pkg::STAMP_W-1:0]  op_b,
	output bsti_pkg::chain_stat_t         stat,
	output logic [bsti_pkg::STAMP_W-1:0]  rd_stamp0
);
	import bsti_pkg::*;

	localparam int NGRP = (TABLE_DEPTH + GRP_W - 1) / GRP_W;

	cell_flags_t        flags [TABLE_DEPTH];
	logic [STAMP_W-1:0] stamps [TABLE_DEPTH];
	logic [STAMP_W-1:0] rd_stamps [TABLE_DEPTH];
	logic               prev_lt [TABLE_DEPTH];
	logic [STAMP_W-1:0] prev_stamp [TABLE_DEPTH];
	cell_flags_t        next_flags [TABLE_DEPTH];
	logic [STAMP_W-1:0] next_stamp [TABLE_DEPTH];
	logic [STAMP_W-1:0] next_rd_stamp [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] eq_v;
	logic [TABLE_DEPTH-1:0] kill_v;
	logic [NGRP*GRP_W-1:0] eq_pad;
	logic [NGRP*GRP_W-1:0] kill_pad;
	logic [NGRP-1:0] dup_grp_q;
	logic [NGRP-1:0] kill_grp_q;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_lt[i] = 1'b1;
			assign prev_stamp[i] = '0;
		end else begin : g_body
			assign prev_lt[i] = flags[i-1].lt;
			assign prev_stamp[i] = stamps[i-1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign next_flags[i] = '0;
			assign next_stamp[i] = '0;
			assign next_rd_stamp[i] = '0;
		end else begin : g_link
			assign next_flags[i] = flags[i+1];
			assign next_stamp[i] = stamps[i+1];
			assign next_rd_stamp[i] = rd_stamps[i+1];
		end

		bsti_cell #(
			.IDX  (i),
			.CNT_W(CNT_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.count        (count),
			.op_a         (op_a),
			.op_b         (op_b),
			.prev_lt      (prev_lt[i]),
			.prev_stamp   (prev_stamp[i]),
			.next_flags   (next_flags[i]),
			.next_stamp   (next_stamp[i]),
			.next_rd_stamp(next_rd_stamp[i]),
			.flags        (flags[i]),
			.stamp        (stamps[i]),
			.rd_stamp     (rd_stamps[i]),
			.eq           (eq_v[i]),
			.kill         (kill_v[i])
		);
	end

	always_comb begin
		eq_pad = '0;
		kill_pad = '0;
		eq_pad[TABLE_DEPTH-1:0] = eq_v;
		kill_pad[TABLE_DEPTH-1:0] = kill_v;
	end

	// first level of the duplicate / past-the-end reduction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_grp_q <= '0;
			kill_grp_q <= '0;
		end else begin
			for (int g = 0; g < NGRP; g++) begin
				dup_grp_q[g] <= |eq_pad[g*GRP_W +: GRP_W];
				kill_grp_q[g] <= |kill_pad[g*GRP_W +: GRP_W];
			end
		end
	end

	assign stat.dup = |dup_grp_q;
	assign stat.kill = |kill_grp_q;
	assign stat.le_s0 = flags[0].le_s;
	assign stat.le_b0 = flags[0].le_b;
	assign stat.rd_tag0 = flags[0].rd_tag;
	assign stat.rd_last0 = flags[0].rd_last;
	assign rd_stamp0 = rd_stamps[0];

endmodule

FILE: src/bounded_sorted_timestamp_index_core.sv
// insert or not-found query: a single result, registered in ST_DEC after the ST_CMP and
//   ST_RED steps, once the output slot is free
// query: matching entries are tagged and shifted toward cell 0 along the readout chain,
//   one result per cycle while the output accepts; untagged entries pass with no result
// one input transaction at a time; next one taken after the last result is registered
// reset: entry count to zero, max_entries to 240, control idle; stored stamps not cleared
`include "bounded_sorted_timestamp_index_core_defines.svh"

module bounded_sorted_timestamp_index_core #(
	parameter int TABLE_DEPTH = bsti_pkg::DEF_TABLE_DEPTH,
	parameter int MAX_BURST = bsti_pkg::DEF_MAX_BURST
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// stamp, range_start, range_end
	input  logic [bsti_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// func
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// entry_stamp
	output logic [bsti_pkg::STAMP_W-1:0]      m_axis_tdata,
	// status, truncated
	output logic [bsti_pkg::OUT_USER_W-1:0]   m_axis_tuser,
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [bsti_pkg::CFG_W-1:0]        cfg_wdata
);
	import bsti_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int BURST_W = $clog2(MAX_BURST + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_RED,
		ST_DEC,
		ST_READ
	} state_t;

	state_t state_q;
	logic func_q;
	logic [STAMP_W-1:0] op_a_q;
	logic [STAMP_W-1:0] op_b_q;
	logic [CNT_W-1:0] count_q;
	logic [BURST_W-1:0] burst_q;
	logic [CFG_W-1:0] max_entries_q;
	logic m_tvalid_q;
	logic [STAMP_W-1:0] m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;
	logic m_tlast_q;

	chain_ctrl_t ctrl;
	chain_stat_t stat;
	logic [STAMP_W-1:0] rd_stamp0;
	logic [LIM_W-1:0] cfg_ext;
	logic [LIM_W-1:0] limit;
	logic full;
	logic found;
	logic slot_free;
	logic emit;
	logic burst_end;
	logic emit_last;
	logic out_load;
	logic [STATUS_W-1:0] ins_status;

	assign cfg_ext = LIM_W'(max_entries_q);
	assign limit = (cfg_ext == '0) ? LIM_W'(1) :
		((cfg_ext > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : cfg_ext);
	assign full = LIM_W'(count_q) >= limit;
	assign found = stat.le_s0 & stat.le_b0 & ~stat.kill;
	assign slot_free = ~m_tvalid_q | m_axis_tready;
	assign emit = (state_q == ST_READ) & stat.rd_tag0 & slot_free;
	assign burst_end = burst_q == BURST_W'(MAX_BURST - 1);
	assign emit_last = emit & (stat.rd_last0 | burst_end);
	assign out_load = ((state_q == ST_DEC) & slot_free & ~(func_q & found)) | emit;
	assign ins_status = stat.dup ? STS_DUPLICATE : (full ? STS_EVICTED : STS_INSERTED);

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_CMP: begin
				ctrl.cmp_en = 1'b1;
			end
			ST_DEC: begin
				if (slot_free) begin
					if (!func_q) begin
						ctrl.ins_en = ~stat.dup;
						ctrl.evict = full;
					end else begin
						ctrl.rd_load = found;
					end
				end
			end
			ST_READ: begin
				ctrl.rd_shift = ~stat.rd_tag0 | slot_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	bsti_chain #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.CNT_W      (CNT_W)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.count    (count_q),
		.op_a     (op_a_q),
		.op_b     (op_b_q),
		.stat     (stat),
		.rd_stamp0(rd_stamp0)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
		end else if (cfg_we) begin
			max_entries_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			func_q <= 1'b0;
			op_a_q <= '0;
			op_b_q <= '0;
			count_q <= '0;
			burst_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= '0;
			m_tlast_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						func_q <= s_axis_tuser;
						op_a_q <= s_axis_tuser ? s_axis_tdata[2*STAMP_W-1:STAMP_W] :
							s_axis_tdata[STAMP_W-1:0];
						op_b_q <= s_axis_tdata[3*STAMP_W-1:2*STAMP_W];
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_RED;
				end
				ST_RED: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (slot_free) begin
						if (func_q && found) begin
							burst_q <= '0;
							state_q <= ST_READ;
						end else begin
							m_tdata_q <= '0;
							m_tlast_q <= 1'b1;
							if (!func_q) begin
								m_tuser_q <= {1'b0, ins_status};
								if (!stat.dup && !full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end else begin
								m_tuser_q <= {1'b0, STS_NOTFOUND};
							end
							state_q <= ST_IDLE;
						end
					end
				end
				ST_READ: begin
					if (emit) begin
						m_tdata_q <= rd_stamp0;
						m_tuser_q <= {burst_end & ~stat.rd_last0, STS_ENTRY};
						m_tlast_q <= emit_last;
						burst_q <= burst_q + BURST_W'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata = m_tdata_q;
	assign m_axis_tuser = m_tuser_q;
	assign m_axis_tlast = m_tlast_q;

	`BSTI_ASSERT_NEXT(a_count_hold, state_q != ST_DEC, count_q == $past(count_q), "count moved")
	`BSTI_ASSERT_IMPL(a_burst_bound, state_q == ST_READ, burst_q < BURST_W'(MAX_BURST), "burst")
	`BSTI_ASSERT_NEXT(a_last_idle, emit_last, state_q == ST_IDLE, "readout went on after last")

endmodule

FILE: tb/tb_bounded_sorted_timestamp_index_core.sv
module tb_bounded_sorted_timestamp_index_core;
	import bsti_pkg::*;

	localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
	localparam int MAX_BURST = DEF_MAX_BURST;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;
	localparam bit FUNC_INSERT = 1'b0;
	localparam bit FUNC_QUERY = 1'b1;
	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

	typedef struct {
		bit                 func;
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] range_start;
		logic [STAMP_W-1:0] range_end;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [STAMP_W-1:0]  entry_stamp;
		logic                last;
		logic                truncated;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [STAMP_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// testbench state
	cmd_t cmd_queue[$];
	result_t want_results[$];
	logic [STAMP_W-1:0] used_stamps[$];
	logic [STAMP_W-1:0] stamp_tbl[TABLE_DEPTH];
	int n_stamps = 0;
	logic [CFG_W-1:0] limit_reg = MAX_ENTRIES_RST;
	bit in_fire = 1'b0;
	bit calm = 1'b0;
	int hold_asks = 0;
	int holds_done = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int cycles = 0;
	int fail_count = 0;
	int n_checked = 0;
	int n_inserts = 0, n_dups = 0, n_evicts = 0;
	int n_queries = 0, n_notfound = 0, n_trunc = 0;

	bounded_sorted_timestamp_index_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int active_limit();
		int lim;
		lim = limit_reg;
		if (lim < 1) lim = 1;
		if (lim > TABLE_DEPTH) lim = TABLE_DEPTH;
		return lim;
	endfunction

	function automatic int floor_slot(logic [STAMP_W-1:0] v);
		int i;
		i = n_stamps - 1;
		while (i >= 0 && stamp_tbl[i] > v) i--;
		return i;
	endfunction

	function automatic void push_result(logic [STATUS_W-1:0] st, logic [STAMP_W-1:0] ts,
			bit lst, bit tr);
		result_t r;
		r.status = st;
		r.entry_stamp = ts;
		r.last = lst;
		r.truncated = tr;
		want_results = {want_results, r};
	endfunction

	function automatic void index_insert(logic [STAMP_W-1:0] ts);
		int p;
		p = 0;
		n_inserts++;
		while (p < n_stamps && stamp_tbl[p] < ts) p++;
		if (p < n_stamps && stamp_tbl[p] == ts) begin
			n_dups++;
			push_result(STS_DUPLICATE, '0, 1'b1, 1'b0);
		end else if (n_stamps + 1 > active_limit()) begin
			// smallest entry goes, which may be the new stamp itself
			if (p > 0) begin
				for (int i = 0; i + 1 < p; i++) stamp_tbl[i] = stamp_tbl[i + 1];
				stamp_tbl[p - 1] = ts;
			end
			n_evicts++;
			push_result(STS_EVICTED, '0, 1'b1, 1'b0);
		end else begin
			for (int i = n_stamps; i > p; i--) stamp_tbl[i] = stamp_tbl[i - 1];
			stamp_tbl[p] = ts;
			n_stamps++;
			push_result(STS_INSERTED, '0, 1'b1, 1'b0);
		end
	endfunction

	function automatic void index_query(logic [STAMP_W-1:0] t_start, logic [STAMP_W-1:0] t_end);
		int si, ei, total, emit;
		n_queries++;
		si = -1;
		ei = -1;
		if (n_stamps > 0 && t_end >= stamp_tbl[0] && t_start <= stamp_tbl[n_stamps - 1]) begin
			si = floor_slot(t_start);
			ei = floor_slot(t_end);
		end
		if (si < 0 || ei < 0) begin
			n_notfound++;
			push_result(STS_NOTFOUND, '0, 1'b1, 1'b0);
		end else if (si <= ei) begin
			total = ei - si + 1;
			emit = (total > MAX_BURST) ? MAX_BURST : total;
			if (total > emit) n_trunc++;
			for (int k = 0; k < emit; k++)
				push_result(STS_ENTRY, stamp_tbl[si + k], k + 1 == emit,
					(k + 1 == emit) && (total > emit));
		end else begin
			// start after end: only the two floor entries, ascending
			push_result(STS_ENTRY, stamp_tbl[ei], MAX_BURST == 1, MAX_BURST == 1);
			if (MAX_BURST > 1) push_result(STS_ENTRY, stamp_tbl[si], 1'b1, 1'b0);
		end
	endfunction

	function automatic logic [STAMP_W-1:0] rand_stamp();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[STAMP_W-1:0];
	endfunction

	function automatic logic [STAMP_W-1:0] pick_insert();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60) return STAMP_W'($urandom_range(0, 4095));
		if (sel < 75 && used_stamps.size() > 0)
			return used_stamps[$urandom_range(0, used_stamps.size() - 1)];
		return rand_stamp();
	endfunction

	function automatic logic [STAMP_W-1:0] pick_point();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50 && used_stamps.size() > 0)
			return used_stamps[$urandom_range(0, used_stamps.size() - 1)]
				+ STAMP_W'($urandom_range(0, 2)) - STAMP_W'(1);
		if (sel < 70) return STAMP_W'($urandom_range(0, 4095));
		return rand_stamp();
	endfunction

	function automatic void push_insert(logic [STAMP_W-1:0] ts);
		cmd_t c;
		c.func = FUNC_INSERT;
		c.stamp = ts;
		c.range_start = rand_stamp();
		c.range_end = rand_stamp();
		used_stamps = {used_stamps, ts};
		cmd_queue = {cmd_queue, c};
	endfunction

	function automatic void push_query(logic [STAMP_W-1:0] t_start, logic [STAMP_W-1:0] t_end);
		cmd_t c;
		c.func = FUNC_QUERY;
		c.stamp = rand_stamp();
		c.range_start = t_start;
		c.range_end = t_end;
		cmd_queue = {cmd_queue, c};
	endfunction

	function automatic void gen_mix(int count, int insert_pct);
		logic [STAMP_W-1:0] a, b, t;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < insert_pct) begin
				push_insert(pick_insert());
			end else begin
				a = pick_point();
				b = pick_point();
				if ($urandom_range(0, 3) != 0 && a > b) begin
					t = a;
					a = b;
					b = t;
				end
				push_query(a, b);
			end
		end
	endfunction

	task automatic wait_drained();
		do @(posedge clk);
		while (cmd_queue.size() > 0 || s_axis_tvalid || want_results.size() > 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_limit(logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// input side driver
	always @(negedge clk) begin : tx_drive
		cmd_t c;
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (cmd_queue.size() > 0) begin
				if (!calm && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(1, 19) - 1;
					s_axis_tvalid <= 1'b0;
				end else begin
					c = cmd_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {c.range_end, c.range_start, c.stamp};
					s_axis_tuser <= c.func;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output side ready, with random stalls and one long hold
	always @(negedge clk) begin : rx_drive
		bit rdy;
		rdy = 1'b0;
		if (arst_n) begin
			if (hold_asks != holds_done) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
			end else begin
				rdy = 1'b1;
			end
			m_axis_tready <= rdy;
		end
	end

	// monitor and checker
	always @(posedge clk) begin : watch
		result_t got, exp_r;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles,
				want_results.size());
			$display("FAILED: results differ");
			$finish;
		end else begin
			in_fire <= arst_n && s_axis_tvalid && s_axis_tready;
			if (arst_n) begin
				if (cfg_we) limit_reg = cfg_wdata;
				if (m_axis_tvalid && m_axis_tready) begin
					got.status = m_axis_tuser[STATUS_W-1:0];
					got.entry_stamp = m_axis_tdata;
					got.last = m_axis_tlast;
					got.truncated = m_axis_tuser[STATUS_W];
					n_checked++;
					if (want_results.size() == 0) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("unexpected transaction: status %0d stamp %h last %b trunc %b",
								got.status, got.entry_stamp, got.last, got.truncated);
					end else begin
						exp_r = want_results.pop_front();
						if (got.status !== exp_r.status || got.entry_stamp !== exp_r.entry_stamp ||
								got.last !== exp_r.last || got.truncated !== exp_r.truncated) begin
							fail_count++;
							if (fail_count <= MAX_REPORTS)
								$display("mismatch: exp status %0d stamp %h last %b trunc %b, got %0d %h %b %b",
									exp_r.status, exp_r.entry_stamp, exp_r.last, exp_r.truncated,
									got.status, got.entry_stamp, got.last, got.truncated);
						end
					end
				end
				if (s_axis_tvalid && s_axis_tready) begin
					if (s_axis_tuser == FUNC_QUERY)
						index_query(s_axis_tdata[2*STAMP_W-1:STAMP_W],
							s_axis_tdata[3*STAMP_W-1:2*STAMP_W]);
					else
						index_insert(s_axis_tdata[STAMP_W-1:0]);
				end
			end
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// directed: small limit so eviction shows up early
		write_limit(9'd3);
		push_query(40'd0, STAMP_MAX);
		push_insert(40'd1000);
		push_insert(40'd2000);
		push_insert(40'd3000);
		push_insert(40'd2000);
		push_insert(40'd4000);
		push_insert(40'd500);
		push_insert(STAMP_MAX);
		push_insert(40'd0);
		push_query(40'd3000, 40'd4000);
		push_query(40'd3500, STAMP_MAX);
		push_query(40'd0, 40'd2999);
		push_query(40'd100, 40'd5000);
		push_query(STAMP_MAX, 40'd3000);
		push_query(40'd4500, 40'd4200);
		push_query(STAMP_MAX, STAMP_MAX);
		push_query(40'd0, 40'd0);
		wait_drained();

		// zero limit acts as one, count stays above it
		write_limit(9'd0);
		push_insert(40'd5000);
		push_insert(40'd4000);
		push_insert(40'd1);
		push_query(40'd0, STAMP_MAX);
		push_query(40'd4000, STAMP_MAX);
		wait_drained();

		// out of range limit clamps to the table depth; long output hold here
		write_limit(9'h1FF);
		gen_mix(150, 75);
		hold_asks++;
		wait_drained();

		write_limit(9'd1);
		gen_mix(30, 60);
		wait_drained();

		write_limit(9'd256);
		gen_mix(30, 60);
		wait_drained();

		// final stretch with no idling on either side
		write_limit(MAX_ENTRIES_RST);
		calm = 1'b1;
		gen_mix(50, 50);
		wait_drained();
		repeat (20) @(posedge clk);

		if (want_results.size() > 0) begin
			$display("%0d expected results never arrived", want_results.size());
			fail_count += want_results.size();
		end
		$display("covered %0d inserts (%0d duplicate, %0d evicting), %0d queries (%0d not found, %0d truncated)",
			n_inserts, n_dups, n_evicts, n_queries, n_notfound, n_trunc);
		$display("%0d result transactions checked in %0d cycles, %0d failures",
			n_checked, cycles, fail_count);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
